// ===== rtl/lcw_pkg.sv =====
`timescale 1ns / 1ps

package lcw_pkg;

    localparam int ID_DEPTH      = 4;
    localparam int ID_BYTE_COUNT = 4;
    localparam int FIFO_CNT_W    = $clog2(ID_DEPTH + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] STATUS_VALUE = 32'hFFFF_FFEF;
    localparam logic [31:0] CMD_ID_LOAD  = 32'h0000_0004;
    localparam logic [31:0] CMD_COL_SET  = 32'h0000_002A;
    localparam logic [31:0] CMD_PAGE_SET = 32'h0000_002B;
    localparam logic [31:0] CMD_MEM_WR   = 32'h0000_002C;

    localparam logic [31:0] FRAME_BASE_RST  = 32'h0FE0_0000;
    localparam logic [11:0] LINE_PIXELS_RST = 12'd320;

    localparam logic [2:0] CFG_ADDR_W = 3'd3;
    localparam logic       CFG_FRAME_BASE  = 1'b0;
    localparam logic       CFG_LINE_PIXELS = 1'b1;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_offset;
        logic        pixel_valid;
        logic [15:0] page;
        logic [16:0] column;
        logic [15:0] pixel_value;
    } t_entry;

    function automatic logic [7:0] id_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h00;
            2'd1: b = 8'h38;
            2'd2: b = 8'hB3;
            default: b = 8'h71;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/lcw_front.sv =====
`timescale 1ns / 1ps

module lcw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_kind,
    input  logic [6:0]           i_offset,
    input  logic [31:0]          i_write_data,
    output lcw_pkg::t_entry      o_entry
);
    import lcw_pkg::*;

    typedef enum logic [3:0] {
        SLOT_CONFIG = 4'd0,
        SLOT_WCMD   = 4'd1,
        SLOT_RCMD   = 4'd2,
        SLOT_RDATA  = 4'd3,
        SLOT_DBUFF  = 4'd4,
        SLOT_INTCON = 4'd5,
        SLOT_PHTIME = 4'd6,
        SLOT_WDATA  = 4'd7,
        SLOT_STATUS = 4'd8,
        SLOT_NONE   = 4'd9
    } t_slot;

    logic [31:0]           r_regs [8];
    logic [FIFO_CNT_W-1:0] r_fifo_count;
    logic [1:0]            r_byte_count;
    logic [15:0]           r_start_col;
    logic [15:0]           r_end_col;
    logic [15:0]           r_start_page;
    logic [15:0]           r_end_page;
    logic [15:0]           r_col_count;

    t_slot       w_slot;
    logic        w_is_reg;
    logic [31:0] w_cmd;
    logic [15:0] w_span;
    logic        w_row_end;
    logic [15:0] w_page;
    logic [15:0] w_col;
    logic [1:0]  w_head;
    logic        w_pix;

    always_comb begin
        unique case (i_offset)
            7'h00:   w_slot = SLOT_CONFIG;
            7'h04:   w_slot = SLOT_WCMD;
            7'h0C:   w_slot = SLOT_RCMD;
            7'h10:   w_slot = SLOT_RDATA;
            7'h14:   w_slot = SLOT_DBUFF;
            7'h18:   w_slot = SLOT_INTCON;
            7'h1C:   w_slot = SLOT_STATUS;
            7'h20:   w_slot = SLOT_PHTIME;
            7'h40:   w_slot = SLOT_WDATA;
            default: w_slot = SLOT_NONE;
        endcase
    end

    assign w_is_reg  = (w_slot != SLOT_STATUS) && (w_slot != SLOT_NONE);
    assign w_cmd     = r_regs[3'(SLOT_WCMD)];
    assign w_span    = r_end_col - r_start_col;
    assign w_row_end = r_col_count > w_span;
    assign w_page    = w_row_end ? r_start_page + 16'd1 : r_start_page;
    assign w_col     = w_row_end ? 16'd0 : r_col_count;
    assign w_head    = 2'(FIFO_CNT_W'(ID_BYTE_COUNT) - r_fifo_count);
    assign w_pix     = i_kind && (w_slot == SLOT_WDATA) && (w_cmd == CMD_MEM_WR);

    always_comb begin
        o_entry = '0;
        o_entry.bad_offset = (w_slot == SLOT_NONE);
        if (!i_kind) begin
            if (w_slot == SLOT_STATUS) begin
                o_entry.read_data = STATUS_VALUE;
            end else if (w_is_reg) begin
                o_entry.read_data = r_regs[w_slot[2:0]];
            end
        end
        if (w_pix) begin
            o_entry.pixel_valid = 1'b1;
            o_entry.page        = w_page;
            o_entry.column      = {1'b0, r_start_col} + {1'b0, w_col};
            o_entry.pixel_value = i_write_data[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= '0;
            end
            r_fifo_count <= '0;
            r_byte_count <= '0;
            r_start_col  <= '0;
            r_end_col    <= '0;
            r_start_page <= '0;
            r_end_page   <= '0;
            r_col_count  <= '0;
        end else if (i_accept && i_kind && w_is_reg) begin
            r_regs[w_slot[2:0]] <= i_write_data;
            unique case (w_slot)
                SLOT_WCMD: begin
                    if (i_write_data == CMD_ID_LOAD) begin
                        r_fifo_count <= FIFO_CNT_W'(ID_BYTE_COUNT);
                    end else if (i_write_data == CMD_MEM_WR) begin
                        r_byte_count <= '0;
                        r_col_count  <= '0;
                    end
                end
                SLOT_RDATA: begin
                    if (i_write_data == '0) begin
                        if (r_fifo_count == '0) begin
                            r_regs[3'(SLOT_DBUFF)] <= '0;
                        end else begin
                            r_regs[3'(SLOT_DBUFF)] <= {23'd0, id_byte(w_head), 1'b0};
                            r_fifo_count           <= r_fifo_count - 1'b1;
                        end
                    end
                end
                SLOT_WDATA: begin
                    if (w_cmd == CMD_COL_SET) begin
                        if (!r_byte_count[1]) begin
                            r_start_col <= {r_start_col[7:0], i_write_data[7:0]};
                        end else begin
                            r_end_col <= {r_end_col[7:0], i_write_data[7:0]};
                        end
                        r_byte_count <= r_byte_count + 2'd1;
                    end else if (w_cmd == CMD_PAGE_SET) begin
                        if (!r_byte_count[1]) begin
                            r_start_page <= {r_start_page[7:0], i_write_data[7:0]};
                        end else begin
                            r_end_page <= {r_end_page[7:0], i_write_data[7:0]};
                        end
                        r_byte_count <= r_byte_count + 2'd1;
                    end else if (w_cmd == CMD_MEM_WR) begin
                        r_start_page <= w_page;
                        r_col_count  <= w_col + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/lcw_queue.sv =====
`timescale 1ns / 1ps

module lcw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcw_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lcw_pkg::t_entry o_entry
);
    import lcw_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("beat pushed into full queue");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on push");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not fall on pop");
`endif

endmodule

// ===== rtl/lcw_back.sv =====
`timescale 1ns / 1ps

module lcw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  lcw_pkg::t_entry i_entry,
    output logic            o_pop,
    input  logic [31:0]     i_frame_base,
    input  logic [11:0]     i_line_pixels,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_read_data,
    output logic            o_bad_offset,
    output logic            o_pixel_valid,
    output logic [31:0]     o_pixel_address,
    output logic [15:0]     o_pixel_value
);
    import lcw_pkg::*;

    logic        r_s1_valid;
    t_entry      r_s1;
    logic [27:0] r_s1_prod;
    logic        r_s2_valid;

    logic        w_s2_ready;
    logic        w_s1_ready;
    logic [28:0] w_index;
    logic [31:0] w_addr;

    assign w_s2_ready = !r_s2_valid || !i_out_stall;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_pop      = !i_q_empty && w_s1_ready;
    assign w_index    = {1'b0, r_s1_prod} + {12'd0, r_s1.column};
    assign w_addr     = i_frame_base + {2'b00, w_index, 1'b0};
    assign o_out_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= !i_q_empty;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1      <= i_entry;
            r_s1_prod <= 28'(i_entry.page) * 28'(i_line_pixels);
        end
        if (w_s2_ready && r_s1_valid) begin
            o_read_data     <= r_s1.read_data;
            o_bad_offset    <= r_s1.bad_offset;
            o_pixel_valid   <= r_s1.pixel_valid;
            o_pixel_address <= r_s1.pixel_valid ? w_addr : '0;
            o_pixel_value   <= r_s1.pixel_valid ? r_s1.pixel_value : '0;
        end
    end

endmodule

// ===== rtl/lcd_command_window_pixel_writer.sv =====
`timescale 1ns / 1ps

// Bus register block of an LCD controller with a column/page window and a
// pixel writer. Access beats are taken one per cycle while the queue is not
// full, and each gives exactly one result beat. The front decodes the beat
// and updates all register and window state in the cycle it is taken; a
// two-entry queue lets it keep accepting while the back computes the pixel
// address over two stages (page times line length, then base plus twice the
// index) and holds the result. Input stall rises only when that queue is
// full. Configuration registers: frame_base at 0x0, line_pixels at 0x4; no
// clearing pass is needed after reset.

module lcd_command_window_pixel_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [6:0]  i_offset,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_bad_offset,
    output logic        o_pixel_valid,
    output logic [31:0] o_pixel_address,
    output logic [15:0] o_pixel_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcw_pkg::*;

    logic [31:0] r_frame_base;
    logic [11:0] r_line_pixels;

    logic   w_accept;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_pop;
    t_entry w_front_entry;
    t_entry w_q_entry;

    assign pready     = 1'b1;
    assign o_in_stall = w_q_full;
    assign w_accept   = i_in_valid && !w_q_full;
    assign prdata     = (paddr[2] == CFG_LINE_PIXELS) ? {20'd0, r_line_pixels} : r_frame_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base  <= FRAME_BASE_RST;
            r_line_pixels <= LINE_PIXELS_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CFG_FRAME_BASE) begin
                r_frame_base <= pwdata;
            end else begin
                r_line_pixels <= pwdata[11:0];
            end
        end
    end

    lcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .o_entry      (w_front_entry)
    );

    lcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_entry (w_q_entry)
    );

    lcw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_entry         (w_q_entry),
        .o_pop           (w_pop),
        .i_frame_base    (r_frame_base),
        .i_line_pixels   (r_line_pixels),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_data     (o_read_data),
        .o_bad_offset    (o_bad_offset),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value)
    );

endmodule

// ===== test/lcd_command_window_pixel_writer_tb.sv =====
`timescale 1ns / 1ps

module lcd_command_window_pixel_writer_tb;
    import lcw_pkg::*;

    localparam logic       ACC_READ  = 1'b0;
    localparam logic       ACC_WRITE = 1'b1;

    localparam logic [6:0] OFS_CONFIG = 7'h00;
    localparam logic [6:0] OFS_WCMD   = 7'h04;
    localparam logic [6:0] OFS_RCMD   = 7'h0C;
    localparam logic [6:0] OFS_RDATA  = 7'h10;
    localparam logic [6:0] OFS_DBUFF  = 7'h14;
    localparam logic [6:0] OFS_INTCON = 7'h18;
    localparam logic [6:0] OFS_STATUS = 7'h1C;
    localparam logic [6:0] OFS_PHTIME = 7'h20;
    localparam logic [6:0] OFS_WDATA  = 7'h40;
    localparam logic [6:0] REG_OFFSETS [9] = '{OFS_CONFIG, OFS_WCMD, OFS_RCMD, OFS_RDATA,
                                               OFS_DBUFF, OFS_INTCON, OFS_STATUS,
                                               OFS_PHTIME, OFS_WDATA};

    localparam logic [31:0] CMD_NONE_104 = 32'h0000_0104;
    localparam logic [31:0] CMD_CHOICES [6] = '{CMD_ID_LOAD, CMD_COL_SET, CMD_PAGE_SET,
                                                CMD_MEM_WR, CMD_NONE_104, 32'h0};
    localparam logic [7:0]  ID_BYTES [4] = '{8'h00, 8'h38, 8'hB3, 8'h71};

    localparam logic [2:0] FRAME_BASE_ADDR  = {CFG_FRAME_BASE, 2'b00};
    localparam logic [2:0] LINE_PIXELS_ADDR = {CFG_LINE_PIXELS, 2'b00};

    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        SLOT_CONFIG, SLOT_WCMD, SLOT_RCMD, SLOT_RDATA, SLOT_DBUFF,
        SLOT_INTCON, SLOT_PHTIME, SLOT_WDATA, SLOT_STATUS, SLOT_NONE
    } reg_slot_e;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_offset;
        logic        pixel_valid;
        logic [31:0] pixel_address;
        logic [15:0] pixel_value;
    } access_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [6:0]  i_offset;
    logic [31:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_read_data;
    logic        o_bad_offset;
    logic        o_pixel_valid;
    logic [31:0] o_pixel_address;
    logic [15:0] o_pixel_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predicted block state
    logic [31:0] frame_base   = FRAME_BASE_RST;
    logic [11:0] line_pixels  = LINE_PIXELS_RST;
    logic [31:0] shadow_regs [8] = '{default: '0};
    int          id_head      = 0;
    int          id_count     = 0;
    logic [1:0]  latch_count  = '0;
    logic [15:0] start_column = '0;
    logic [15:0] end_column   = '0;
    logic [15:0] start_page   = '0;
    logic [15:0] end_page     = '0;
    logic [15:0] column_count = '0;

    access_result_t pending_results [$];
    int             error_count = 0;
    int             beats_sent  = 0;
    int             beats_seen  = 0;
    bit             no_idle     = 1'b0;

    lcd_command_window_pixel_writer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_offset        (i_offset),
        .i_write_data    (i_write_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_data     (o_read_data),
        .o_bad_offset    (o_bad_offset),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch on result beat %0d: %s", $time, beats_seen, msg);
    endtask

    function automatic reg_slot_e decode_offset(input logic [6:0] ofs);
        case (ofs)
            OFS_CONFIG: return SLOT_CONFIG;
            OFS_WCMD:   return SLOT_WCMD;
            OFS_RCMD:   return SLOT_RCMD;
            OFS_RDATA:  return SLOT_RDATA;
            OFS_DBUFF:  return SLOT_DBUFF;
            OFS_INTCON: return SLOT_INTCON;
            OFS_STATUS: return SLOT_STATUS;
            OFS_PHTIME: return SLOT_PHTIME;
            OFS_WDATA:  return SLOT_WDATA;
            default:    return SLOT_NONE;
        endcase
    endfunction

    // first two bytes go to the start value, next two to the end value
    function automatic void shift_window_byte(inout logic [15:0] first,
                                              inout logic [15:0] second,
                                              input logic [7:0] b);
        if (latch_count < 2'd2) begin
            first = {first[7:0], b};
        end else begin
            second = {second[7:0], b};
        end
        latch_count = latch_count + 2'd1;
    endfunction

    function automatic access_result_t predict_access(input logic kind,
                                                      input logic [6:0] ofs,
                                                      input logic [31:0] data);
        access_result_t res;
        reg_slot_e      slot;
        logic [15:0]    span;
        logic [31:0]    index;
        res = '0;
        slot = decode_offset(ofs);
        if (slot == SLOT_NONE) begin
            res.bad_offset = 1'b1;
        end else if (kind == ACC_READ) begin
            res.read_data = (slot == SLOT_STATUS) ? STATUS_VALUE : shadow_regs[slot];
        end else if (slot != SLOT_STATUS) begin
            shadow_regs[slot] = data;
            if (slot == SLOT_WCMD) begin
                if (data == CMD_ID_LOAD) begin
                    id_head  = 0;
                    id_count = ID_BYTE_COUNT;
                end else if (data == CMD_MEM_WR) begin
                    latch_count  = '0;
                    column_count = '0;
                end
            end else if (slot == SLOT_RDATA && data == 32'h0) begin
                if (id_count == 0 || id_head >= ID_DEPTH) begin
                    shadow_regs[SLOT_DBUFF] = '0;
                end else begin
                    shadow_regs[SLOT_DBUFF] = {23'd0, ID_BYTES[id_head], 1'b0};
                    id_head++;
                    id_count--;
                end
            end else if (slot == SLOT_WDATA) begin
                if (shadow_regs[SLOT_WCMD] == CMD_COL_SET) begin
                    shift_window_byte(start_column, end_column, data[7:0]);
                end else if (shadow_regs[SLOT_WCMD] == CMD_PAGE_SET) begin
                    shift_window_byte(start_page, end_page, data[7:0]);
                end else if (shadow_regs[SLOT_WCMD] == CMD_MEM_WR) begin
                    span = end_column - start_column;
                    if (column_count > span) begin
                        start_page   = start_page + 16'd1;
                        column_count = '0;
                    end
                    index = start_page * line_pixels + start_column + column_count;
                    res.pixel_valid   = 1'b1;
                    res.pixel_address = frame_base + (index << 1);
                    res.pixel_value   = data[15:0];
                    column_count      = column_count + 16'd1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        access_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              o_read_data, want.read_data));
                if (o_bad_offset !== want.bad_offset)
                    report_mismatch($sformatf("bad_offset %b, expected %b",
                                              o_bad_offset, want.bad_offset));
                if (o_pixel_valid !== want.pixel_valid)
                    report_mismatch($sformatf("pixel_valid %b, expected %b",
                                              o_pixel_valid, want.pixel_valid));
                if (o_pixel_address !== want.pixel_address)
                    report_mismatch($sformatf("pixel_address %h, expected %h",
                                              o_pixel_address, want.pixel_address));
                if (o_pixel_value !== want.pixel_value)
                    report_mismatch($sformatf("pixel_value %h, expected %h",
                                              o_pixel_value, want.pixel_value));
            end
        end
    end

    // output-side backpressure
    initial begin : out_stall_gen
        int hold;
        int r;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (no_idle || r < 55) begin
                    i_out_stall = 1'b0;
                    hold = $urandom_range(0, 6);
                end else if (r < 92) begin
                    i_out_stall = 1'b1;
                    hold = $urandom_range(0, 2);
                end else begin
                    i_out_stall = 1'b1;
                    hold = $urandom_range(5, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // drives one access beat, returns once it is taken; valid stays high
    task automatic send_access(input logic kind, input logic [6:0] ofs,
                               input logic [31:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_kind       = kind;
        i_offset     = ofs;
        i_write_data = data;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_access(kind, ofs, data));
        beats_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == FRAME_BASE_ADDR) frame_base = data;
        else if (addr == LINE_PIXELS_ADDR) line_pixels = data[11:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_frame_layout(input logic [31:0] base, input logic [11:0] pixels);
        drain_results();
        apb_write(FRAME_BASE_ADDR, base);
        apb_write(LINE_PIXELS_ADDR, {20'd0, pixels});
    endtask

    // window command then data bytes: start hi, start lo, end hi, end lo, repeating
    task automatic send_window(input logic [31:0] cmd, input logic [15:0] first,
                               input logic [15:0] last, input int n_bytes);
        logic [7:0]  bytes [4];
        logic [31:0] data;
        bytes = '{first[15:8], first[7:0], last[15:8], last[7:0]};
        send_access(ACC_WRITE, OFS_WCMD, cmd);
        for (int i = 0; i < n_bytes; i++) begin
            data = $urandom();
            data[7:0] = bytes[i % 4];
            send_access(ACC_WRITE, OFS_WDATA, data);
        end
    endtask

    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 20));
        if (r < 70) return 16'($urandom_range(16'hFFFA, 16'hFFFF));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [15:0] pick_span();
        if ($urandom_range(0, 99) < 75) return 16'($urandom_range(0, 6));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic ACC_KIND();
        return $urandom_range(0, 1) ? ACC_WRITE : ACC_READ;
    endfunction

    task automatic test_register_map();
        send_access(ACC_READ,  OFS_STATUS, 32'h0);
        send_access(ACC_WRITE, OFS_STATUS, 32'h0);
        send_access(ACC_READ,  OFS_STATUS, 32'hFFFF_FFFF);
        send_access(ACC_WRITE, OFS_CONFIG, 32'hFFFF_FFFF);
        send_access(ACC_READ,  OFS_CONFIG, 32'h0);
        send_access(ACC_READ,  7'h7F, 32'h0);
        send_access(ACC_WRITE, 7'h08, 32'hFFFF_FFFF);
        send_access(ACC_READ,  7'h44, 32'h0);
    endtask

    task automatic test_id_fifo();
        send_access(ACC_WRITE, OFS_WCMD, CMD_NONE_104);
        send_access(ACC_WRITE, OFS_WCMD, CMD_ID_LOAD);
        send_access(ACC_WRITE, OFS_RDATA, 32'h1);
        send_access(ACC_WRITE, OFS_RDATA, 32'h0);
        send_access(ACC_WRITE, OFS_RDATA, 32'h0);
        send_access(ACC_READ,  OFS_DBUFF, 32'h0);
        send_access(ACC_WRITE, OFS_RDATA, 32'h0);
        send_access(ACC_WRITE, OFS_RDATA, 32'h0);
        send_access(ACC_READ,  OFS_DBUFF, 32'h0);
        // fifo now empty
        send_access(ACC_WRITE, OFS_RDATA, 32'h0);
        send_access(ACC_READ,  OFS_DBUFF, 32'h0);
    endtask

    task automatic test_window_pixels();
        send_window(CMD_COL_SET, 16'h0005, 16'h0006, 4);
        send_window(CMD_PAGE_SET, 16'hFFFF, 16'h0000, 4);
        send_access(ACC_WRITE, OFS_WCMD, CMD_MEM_WR);
        send_access(ACC_WRITE, OFS_WDATA, 32'hFFFF_FFFF);
        send_access(ACC_WRITE, OFS_WDATA, 32'h0000_0000);
        // row done: page wraps to zero
        send_access(ACC_WRITE, OFS_WDATA, 32'h1234_A5C3);
    endtask

    task automatic run_traffic(input int n_items);
        int          stop;
        int          r;
        int          n;
        logic [15:0] first;
        logic [31:0] data;
        stop = beats_sent + n_items;
        while (beats_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                first = pick_coord();
                send_window(CMD_COL_SET, first, first + pick_span(),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4);
                first = pick_coord();
                send_window(CMD_PAGE_SET, first, first + pick_span(),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 4);
                send_access(ACC_WRITE, OFS_WCMD, CMD_MEM_WR);
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_access(ACC_READ, REG_OFFSETS[$urandom_range(0, 8)], $urandom());
                    send_access(ACC_WRITE, OFS_WDATA, $urandom());
                end
            end else if (r < 60) begin
                send_access(ACC_WRITE, OFS_WCMD, CMD_ID_LOAD);
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    data = ($urandom_range(0, 4) == 0) ? $urandom() : 32'h0;
                    send_access(ACC_WRITE, OFS_RDATA, data);
                    send_access(ACC_READ, OFS_DBUFF, $urandom());
                end
            end else if (r < 80) begin
                n = $urandom_range(0, 99);
                if (n < 25) data = CMD_CHOICES[$urandom_range(0, 5)];
                else if (n < 40) data = 32'h0;
                else data = $urandom();
                send_access(ACC_KIND(), REG_OFFSETS[$urandom_range(0, 8)], data);
            end else begin
                data = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom();
                send_access(ACC_KIND(), 7'($urandom_range(0, 127)), data);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(440);
        set_frame_layout(32'h0000_0000, 12'd4095);
        no_idle = 1'b1;
        run_traffic(420);
        no_idle = 1'b0;
        set_frame_layout(32'hFFFF_FFFF, 12'd1);
        run_traffic(440);
        set_frame_layout($urandom(), 12'($urandom_range(1, 4095)));
        run_traffic(440);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = ACC_READ;
        i_offset     = '0;
        i_write_data = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_map();
        test_id_fifo();
        test_window_pixels();
        test_random_traffic();

        drain_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
